/* hdl/rti_pkg.sv */
// Shared types and constants for the ray / triangle intersection tester.
// No dependencies; imported by rti_mul, rti_div, ray_triangle_intersect and the testbench.
package rti_pkg;

    localparam int LIMB_WIDTH      = 32;
    localparam int QUO_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_VERTEX_A = 2'd0,
        REG_VERTEX_B = 2'd1,
        REG_VERTEX_C = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        REASON_HIT      = 2'd0,
        REASON_PARALLEL = 2'd1,
        REASON_BEHIND   = 2'd2,
        REASON_OUTSIDE  = 2'd3
    } miss_reason_t;

    typedef struct packed {
        logic         hit;
        miss_reason_t reason;
    } result_flags_t;

endpackage

/* hdl/ray_triangle_intersect.sv */
// Ray / triangle intersection tester: plane hit, edge tests and Q16.16 distance.
// Depends on rti_pkg, rti_mul and rti_div.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | origin xyz, direction xyz
//  m_      | out       | m_valid / m_ready    | hit, distance, miss reason
//  cfg_    | in        | cfg_valid / cfg_ready| register index, data
//
// One ray per cycle while the output is not stalled; each ray passes through the product
// stages, the one-bit-per-stage divider and the output register.
// Synchronous active-low reset clears valid bits and vertex registers.
// A result held at the output stalls the whole pipeline on one shared enable.
module ray_triangle_intersect #(
    parameter int COORD_WIDTH   = 16,
    parameter int DIST_FRACTION = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rti_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [3*COORD_WIDTH-1:0]              cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_WIDTH-1:0]         s_origin_x,
    input  logic signed [COORD_WIDTH-1:0]         s_origin_y,
    input  logic signed [COORD_WIDTH-1:0]         s_origin_z,
    input  logic signed [COORD_WIDTH-1:0]         s_dir_x,
    input  logic signed [COORD_WIDTH-1:0]         s_dir_y,
    input  logic signed [COORD_WIDTH-1:0]         s_dir_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [rti_pkg::QUO_WIDTH-1:0]         m_distance,
    output logic [1:0]                            m_miss_reason
);
    import rti_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int DW1    = W + 1;
    localparam int XW     = 2 * W + 3;
    localparam int DTW    = 2 * XW + 2;
    localparam int VW     = 2 * DTW + 1;
    localparam int NCROSS = 7;
    localparam int NDOT   = 8;
    localparam int NVLD   = 13;
    localparam int NDLY   = 4;
    localparam int FW     = $bits(result_flags_t);

    logic ce;

    // vertex registers
    logic [3*W-1:0] va_reg, vb_reg, vc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= '0;
            vb_reg <= '0;
            vc_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_VERTEX_A: va_reg <= cfg_data;
                REG_VERTEX_B: vb_reg <= cfg_data;
                REG_VERTEX_C: vc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // valid chain through the product stages
    logic vld_reg [NVLD];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NVLD; i++) vld_reg[i] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NVLD; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 0: differences
    logic signed [W-1:0]   va [3], vb [3], vc [3], org [3], dir [3];
    logic signed [DW1-1:0] e_reg  [3][3];
    logic signed [DW1-1:0] os_reg [3][3];
    logic signed [DW1-1:0] ac_reg [3];
    logic signed [DW1-1:0] ao_reg [3];
    logic signed [DW1-1:0] d_reg  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            va[k] = signed'(va_reg[k*W +: W]);
            vb[k] = signed'(vb_reg[k*W +: W]);
            vc[k] = signed'(vc_reg[k*W +: W]);
        end
        org[0] = s_origin_x;
        org[1] = s_origin_y;
        org[2] = s_origin_z;
        dir[0] = s_dir_x;
        dir[1] = s_dir_y;
        dir[2] = s_dir_z;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                e_reg[0][k]  <= DW1'(vb[k]) - DW1'(va[k]);
                e_reg[1][k]  <= DW1'(vc[k]) - DW1'(vb[k]);
                e_reg[2][k]  <= DW1'(va[k]) - DW1'(vc[k]);
                os_reg[0][k] <= DW1'(org[k]) - DW1'(va[k]);
                os_reg[1][k] <= DW1'(org[k]) - DW1'(vb[k]);
                os_reg[2][k] <= DW1'(org[k]) - DW1'(vc[k]);
                ac_reg[k]    <= DW1'(vc[k]) - DW1'(va[k]);
                ao_reg[k]    <= DW1'(va[k]) - DW1'(org[k]);
                d_reg[k]     <= DW1'(dir[k]);
            end
        end
    end

    // cross products: normal, edge x (o - start), edge x d
    logic signed [DW1-1:0]   xa [NCROSS][3];
    logic signed [DW1-1:0]   xb [NCROSS][3];
    logic signed [2*DW1-1:0] pa [NCROSS][3];
    logic signed [2*DW1-1:0] pb [NCROSS][3];
    logic signed [XW-1:0]    xr_reg [NCROSS][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            xa[0][k] = e_reg[0][k];
            xb[0][k] = ac_reg[k];
            for (int i = 0; i < 3; i++) begin
                xa[1+i][k] = e_reg[i][k];
                xb[1+i][k] = os_reg[i][k];
                xa[4+i][k] = e_reg[i][k];
                xb[4+i][k] = d_reg[k];
            end
        end
    end

    for (genvar g = 0; g < NCROSS; g++) begin : g_cross
        for (genvar k = 0; k < 3; k++) begin : g_comp
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;
            rti_mul #(.AW(DW1), .BW(DW1)) u_pa (
                .clk(aclk), .ce(ce), .a(xa[g][K1]), .b(xb[g][K2]), .p(pa[g][k])
            );
            rti_mul #(.AW(DW1), .BW(DW1)) u_pb (
                .clk(aclk), .ce(ce), .a(xa[g][K2]), .b(xb[g][K1]), .p(pb[g][k])
            );
        end
    end

    logic signed [DW1-1:0] d_dly_reg  [NDLY][3];
    logic signed [DW1-1:0] ao_dly_reg [NDLY][3];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int g = 0; g < NCROSS; g++) begin
                for (int k = 0; k < 3; k++) begin
                    xr_reg[g][k] <= XW'(pa[g][k]) - XW'(pb[g][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                d_dly_reg[0][k]  <= d_reg[k];
                ao_dly_reg[0][k] <= ao_reg[k];
                for (int i = 1; i < NDLY; i++) begin
                    d_dly_reg[i][k]  <= d_dly_reg[i-1][k];
                    ao_dly_reg[i][k] <= ao_dly_reg[i-1][k];
                end
            end
        end
    end

    // dot products with the normal: den, num, edge fixed terms, edge slopes
    logic signed [XW-1:0]   dv [NDOT][3];
    logic signed [2*XW-1:0] pd [NDOT][3];
    logic signed [DTW-1:0]  dot_reg [NDOT];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dv[0][k] = XW'(d_dly_reg[NDLY-1][k]);
            dv[1][k] = XW'(ao_dly_reg[NDLY-1][k]);
            for (int i = 0; i < 3; i++) begin
                dv[2+i][k] = xr_reg[1+i][k];
                dv[5+i][k] = xr_reg[4+i][k];
            end
        end
    end

    for (genvar j = 0; j < NDOT; j++) begin : g_dot
        for (genvar k = 0; k < 3; k++) begin : g_term
            rti_mul #(.AW(XW), .BW(XW)) u_mul (
                .clk(aclk), .ce(ce), .a(xr_reg[0][k]), .b(dv[j][k]), .p(pd[j][k])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int j = 0; j < NDOT; j++) begin
                dot_reg[j] <= DTW'(pd[j][0]) + DTW'(pd[j][1]) + DTW'(pd[j][2]);
            end
        end
    end

    // edge values: den * fixed + num * slope
    logic signed [2*DTW-1:0] pf [3];
    logic signed [2*DTW-1:0] ps [3];
    logic signed [VW-1:0]    v_reg [3];
    logic signed [DTW-1:0]   den_dly_reg [NDLY];
    logic signed [DTW-1:0]   num_dly_reg [NDLY];

    for (genvar i = 0; i < 3; i++) begin : g_edge
        rti_mul #(.AW(DTW), .BW(DTW)) u_fix (
            .clk(aclk), .ce(ce), .a(dot_reg[0]), .b(dot_reg[2+i]), .p(pf[i])
        );
        rti_mul #(.AW(DTW), .BW(DTW)) u_slp (
            .clk(aclk), .ce(ce), .a(dot_reg[1]), .b(dot_reg[5+i]), .p(ps[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) v_reg[i] <= VW'(pf[i]) + VW'(ps[i]);
            den_dly_reg[0] <= dot_reg[0];
            num_dly_reg[0] <= dot_reg[1];
            for (int i = 1; i < NDLY; i++) begin
                den_dly_reg[i] <= den_dly_reg[i-1];
                num_dly_reg[i] <= num_dly_reg[i-1];
            end
        end
    end

    // decisions
    logic signed [DTW-1:0] den, num;
    logic                  den_neg, num_neg, behind, outside;
    logic [2:0]            edge_out;
    logic [DTW-1:0]        den_mag, num_mag;
    result_flags_t         flags;

    always_comb begin
        den     = den_dly_reg[NDLY-1];
        num     = num_dly_reg[NDLY-1];
        den_neg = den[DTW-1];
        num_neg = num[DTW-1];
        behind  = (num != '0) && (num_neg != den_neg);
        for (int i = 0; i < 3; i++) begin
            edge_out[i] = den_neg ? ((v_reg[i] != '0) && !v_reg[i][VW-1]) : v_reg[i][VW-1];
        end
        outside = |edge_out;
        den_mag = den_neg ? DTW'(-den) : DTW'(den);
        num_mag = num_neg ? DTW'(-num) : DTW'(num);
        flags.hit = 1'b0;
        priority if (den == '0) begin
            flags.reason = REASON_PARALLEL;
        end else if (behind) begin
            flags.reason = REASON_BEHIND;
        end else if (outside) begin
            flags.reason = REASON_OUTSIDE;
        end else begin
            flags.reason = REASON_HIT;
            flags.hit    = 1'b1;
        end
    end

    logic                 div_valid;
    logic [QUO_WIDTH-1:0] div_quo;
    logic [FW-1:0]        div_side;
    result_flags_t        div_flags;

    rti_div #(.NW(DTW), .DW(DTW), .FRAC(DIST_FRACTION), .SBW(FW)) u_div (
        .clk       (aclk),
        .rstn      (aresetn),
        .ce        (ce),
        .in_valid  (vld_reg[NVLD-1]),
        .num_mag   (num_mag),
        .den_mag   (den_mag),
        .side_in   (flags),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    assign div_flags = result_flags_t'(div_side);

    // output register
    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic [QUO_WIDTH-1:0] m_distance_reg;
    logic [1:0]           m_miss_reason_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_hit_reg         <= div_flags.hit;
            m_distance_reg    <= div_flags.hit ? div_quo : '0;
            m_miss_reason_reg <= div_flags.reason;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_distance    = m_distance_reg;
    assign m_miss_reason = m_miss_reason_reg;

    a_hit_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit == (m_miss_reason == REASON_HIT)))
        else $error("hit flag disagrees with miss reason");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_distance == '0)
        else $error("distance not zero on a miss");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg[NVLD-1]) && $stable(div_valid))
        else $error("pipeline moved during a stall");

endmodule

/* hdl/rti_mul.sv */
// Pipelined signed multiplier, three register stages, split into 32x32 partial products.
// Depends on rti_pkg (limb width).
module rti_mul #(
    parameter int AW = 17,
    parameter int BW = 17
) (
    input  logic                 clk,
    input  logic                 ce,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);
    import rti_pkg::*;

    localparam int NA = (AW + LIMB_WIDTH - 1) / LIMB_WIDTH;
    localparam int NB = (BW + LIMB_WIDTH - 1) / LIMB_WIDTH;
    localparam int AX = NA * LIMB_WIDTH;
    localparam int BX = NB * LIMB_WIDTH;
    localparam int PW = AW + BW;
    localparam int SW = AX + BX;

    logic [AW-1:0]           a_abs;
    logic [BW-1:0]           b_abs;
    logic [AX-1:0]           am_reg;
    logic [BX-1:0]           bm_reg;
    logic                    neg1_reg;
    logic                    neg2_reg;
    logic [2*LIMB_WIDTH-1:0] pp_reg [NA][NB];
    logic [SW-1:0]           acc;
    logic signed [PW-1:0]    p_reg;

    always_comb begin
        a_abs = a[AW-1] ? AW'(-a) : AW'(a);
        b_abs = b[BW-1] ? BW'(-b) : BW'(b);
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (SW'(pp_reg[i][j]) << (LIMB_WIDTH * (i + j)));
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ce) begin
            am_reg   <= AX'(a_abs);
            bm_reg   <= BX'(b_abs);
            neg1_reg <= a[AW-1] ^ b[BW-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= am_reg[i*LIMB_WIDTH +: LIMB_WIDTH]
                                  * bm_reg[j*LIMB_WIDTH +: LIMB_WIDTH];
                end
            end
            neg2_reg <= neg1_reg;
            p_reg    <= neg2_reg ? PW'(-acc) : PW'(acc);
        end
    end

    assign p = p_reg;

endmodule

/* hdl/rti_div.sv */
// Pipelined restoring divider: one quotient bit per stage, saturating quotient.
// Depends on rti_pkg (quotient width); carries a sideband word alongside.
module rti_div #(
    parameter int NW   = 72,
    parameter int DW   = 72,
    parameter int FRAC = 16,
    parameter int SBW  = 3
) (
    input  logic                           clk,
    input  logic                           rstn,
    input  logic                           ce,
    input  logic                           in_valid,
    input  logic [NW-1:0]                  num_mag,
    input  logic [DW-1:0]                  den_mag,
    input  logic [SBW-1:0]                 side_in,
    output logic                           out_valid,
    output logic [rti_pkg::QUO_WIDTH-1:0]  quo,
    output logic [SBW-1:0]                 side_out
);
    import rti_pkg::*;

    localparam int RW = NW + FRAC;
    localparam int DQ = DW + QUO_WIDTH;
    localparam int CW = ((RW > DQ) ? RW : DQ) + 1;
    localparam int NS = QUO_WIDTH + 1;

    logic                 vld_reg  [NS];
    logic [CW-1:0]        rem_reg  [NS];
    logic [DW-1:0]        den_reg  [NS];
    logic [QUO_WIDTH-1:0] q_reg    [NS];
    logic                 sat_reg  [NS];
    logic [SBW-1:0]       side_reg [NS];
    logic [CW-1:0]        rem_first;

    assign rem_first = CW'(num_mag) << FRAC;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            for (int k = 0; k < NS; k++) vld_reg[k] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk) begin
        if (ce) begin
            rem_reg[0]  <= rem_first;
            den_reg[0]  <= den_mag;
            q_reg[0]    <= '0;
            sat_reg[0]  <= rem_first >= (CW'(den_mag) << QUO_WIDTH);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        localparam int BIT = QUO_WIDTH - k;
        logic [CW-1:0] trial;
        logic          ge;

        always_comb begin
            trial = CW'(den_reg[k-1]) << BIT;
            ge    = rem_reg[k-1] >= trial;
        end

        always_ff @(posedge clk) begin
            if (ce) begin
                rem_reg[k]  <= ge ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                q_reg[k]    <= q_reg[k-1] | (ge ? (QUO_WIDTH'(1) << BIT) : '0);
                den_reg[k]  <= den_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign quo       = sat_reg[NS-1] ? '1 : q_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

/* dv/tb_ray_triangle_intersect.sv */
// Self-checking testbench for ray_triangle_intersect: exact-arithmetic predictor in a
// scoreboard class, valid/ready drivers with random idling and one long output hold-off.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
`timescale 1ns / 100ps

module tb_ray_triangle_intersect;
    import rti_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_CYCLES = 60;
    localparam int STALL_LIMIT = 5000;

    typedef logic signed [255:0] wint_t;
    typedef struct { wint_t x, y, z; } vec3_t;
    typedef struct {
        logic signed [15:0] ox, oy, oz, dx, dy, dz;
    } ray_t;
    typedef struct {
        logic         hit;
        logic [31:0]  distance;
        miss_reason_t reason;
    } outcome_t;

    class intersect_scoreboard;
        logic [47:0] vtx [3];
        outcome_t    pending [$];
        int          errors;

        function new();
            vtx[0] = '0; vtx[1] = '0; vtx[2] = '0;
            errors = 0;
        endfunction

        function vec3_t unpack(logic [47:0] r);
            vec3_t v;
            v.x = wint_t'($signed(r[15:0]));
            v.y = wint_t'($signed(r[31:16]));
            v.z = wint_t'($signed(r[47:32]));
            return v;
        endfunction

        function vec3_t vsub(vec3_t p, vec3_t q);
            vec3_t r;
            r.x = p.x - q.x; r.y = p.y - q.y; r.z = p.z - q.z;
            return r;
        endfunction

        function vec3_t vcross(vec3_t p, vec3_t q);
            vec3_t r;
            r.x = p.y * q.z - p.z * q.y;
            r.y = p.z * q.x - p.x * q.z;
            r.z = p.x * q.y - p.y * q.x;
            return r;
        endfunction

        function wint_t vdot(vec3_t p, vec3_t q);
            return p.x * q.x + p.y * q.y + p.z * q.z;
        endfunction

        function logic outside_edge(vec3_t n, vec3_t s, vec3_t e, vec3_t o, vec3_t d,
                                    wint_t den, wint_t num);
            vec3_t ed;
            wint_t v;
            ed = vsub(e, s);
            v = den * vdot(n, vcross(ed, vsub(o, s))) + num * vdot(n, vcross(ed, d));
            if (den < 0) v = -v;
            return v < 0;
        endfunction

        function outcome_t predict(ray_t ray);
            outcome_t res;
            vec3_t a, b, c, n, o, d;
            wint_t den, num, q;
            a = unpack(vtx[0]); b = unpack(vtx[1]); c = unpack(vtx[2]);
            o.x = wint_t'(ray.ox); o.y = wint_t'(ray.oy); o.z = wint_t'(ray.oz);
            d.x = wint_t'(ray.dx); d.y = wint_t'(ray.dy); d.z = wint_t'(ray.dz);
            n = vcross(vsub(b, a), vsub(c, a));
            res.hit = 1'b0; res.distance = '0;
            den = vdot(n, d);
            num = vdot(n, vsub(a, o));
            if (den == 0) begin
                res.reason = REASON_PARALLEL;
            end else if (num != 0 && ((num < 0) != (den < 0))) begin
                res.reason = REASON_BEHIND;
            end else if (outside_edge(n, a, b, o, d, den, num) ||
                         outside_edge(n, b, c, o, d, den, num) ||
                         outside_edge(n, c, a, o, d, den, num)) begin
                res.reason = REASON_OUTSIDE;
            end else begin
                if (num < 0) num = -num;
                if (den < 0) den = -den;
                q = (num <<< 16) / den;
                res.hit = 1'b1;
                res.reason = REASON_HIT;
                res.distance = (q >= (wint_t'(1) <<< 32)) ? 32'hFFFF_FFFF : q[31:0];
            end
            return res;
        endfunction

        function void note_ray(ray_t ray);
            pending.push_back(predict(ray));
        endfunction

        function void check_result(logic hit, logic [31:0] distance, logic [1:0] reason);
            outcome_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (hit !== e.hit) begin
                $error("hit: expected %0d actual %0d", e.hit, hit);
                errors++;
            end
            if (distance !== e.distance) begin
                $error("distance: expected %h actual %h", e.distance, distance);
                errors++;
            end
            if (reason !== e.reason) begin
                $error("miss_reason: expected %0d actual %0d", e.reason, reason);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    logic signed [15:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [31:0] m_distance;
    logic [1:0] m_miss_reason;

    intersect_scoreboard sb = new();
    logic calm = 1'b0;
    int results_seen = 0;
    int stall_count = 0;

    ray_triangle_intersect dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_distance(m_distance), .m_miss_reason(m_miss_reason)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            sb.check_result(m_hit, m_distance, m_miss_reason);
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            !aresetn)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    initial begin
        logic held;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 60) begin
                held = 1'b1;
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
            end
            m_ready = calm || ($urandom_range(99) >= 9);
        end
    end

    task automatic send_ray(ray_t ray);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 9) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_origin_x = ray.ox; s_origin_y = ray.oy; s_origin_z = ray.oz;
        s_dir_x = ray.dx; s_dir_y = ray.dy; s_dir_z = ray.dz;
        do @(posedge aclk); while (!s_ready);
        sb.note_ray(ray);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [47:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx != REG_UNUSED) sb.vtx[idx] = data;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_triangle(logic [47:0] a, logic [47:0] b, logic [47:0] c);
        drain();
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
    endtask

    function automatic logic [47:0] pack(int x, int y, int z);
        logic [15:0] px, py, pz;
        px = 16'(x); py = 16'(y); pz = 16'(z);
        return {pz, py, px};
    endfunction

    function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_t r;
        r.ox = 16'(ox); r.oy = 16'(oy); r.oz = 16'(oz);
        r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
        return r;
    endfunction

    function automatic int sc(logic [47:0] r, int k);
        logic signed [15:0] v;
        v = r[16*k +: 16];
        return int'(v);
    endfunction

    function automatic int rnd(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    // mostly rays aimed through an interior point, some reversed, rest noise
    function automatic ray_t random_ray();
        int w [3];
        int t [3];
        int o [3];
        int s, k, sh;
        ray_t r;
        if ($urandom_range(99) < 30) begin
            if ($urandom_range(1))
                r = mk(rnd(32768), rnd(32768), rnd(32768),
                       rnd(32768), rnd(32768), rnd(32768));
            else
                r = mk(rnd(32768), rnd(32768), rnd(32768), rnd(2), rnd(2), rnd(2));
            return r;
        end
        for (k = 0; k < 3; k++) w[k] = $urandom_range(7);
        s = w[0] + w[1] + w[2];
        if (s == 0) begin
            w[0] = 1; s = 1;
        end
        sh = $urandom_range(99) < 20 ? $urandom_range(6) : 0;
        for (k = 0; k < 3; k++) begin
            t[k] = (w[0] * sc(sb.vtx[0], k) + w[1] * sc(sb.vtx[1], k) +
                    w[2] * sc(sb.vtx[2], k)) / s;
            o[k] = rnd(8000);
            t[k] = (t[k] - o[k]) >>> sh;
            if ($urandom_range(99) < 20) t[k] = -t[k];
        end
        return mk(o[0], o[1], o[2], t[0], t[1], t[2]);
    endfunction

    function automatic logic [47:0] small_vertex();
        return pack(rnd(8000), rnd(8000), rnd(8000));
    endfunction

    initial begin
        int ph, i;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // degenerate triangle straight after reset
        send_ray(mk(0, 0, 0, 256, 0, 0));
        send_ray(mk(-32768, 32767, -32768, 32767, -32768, 32767));

        set_triangle(pack(-32768, -32768, 0), pack(32767, -32768, 0), pack(0, 32767, 0));
        write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_ray(mk(0, 0, 32767, 0, 0, -32768));
        send_ray(mk(0, 0, 32767, 0, 0, 32767));
        send_ray(mk(0, 0, 256, 1, 0, 0));
        send_ray(mk(32767, 32767, 256, 0, 0, -1));
        send_ray(mk(0, 0, 0, 0, 0, 1));
        send_ray(mk(0, -32768, 256, 0, 0, -1));
        send_ray(mk(-32768, -32768, -32768, 32767, 32767, 32767));
        send_ray(mk(32767, 32767, 32767, -32768, -32768, -32768));
        send_ray(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        send_ray(mk(100, 100, -32768, 0, 0, 1));
        send_ray(mk(0, 0, 0, 0, 0, 0));

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_triangle(small_vertex(), small_vertex(), small_vertex());
                1: set_triangle(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                48'({$urandom, $urandom}));
                2: set_triangle(pack(1, 1, 1), pack(2, 2, 2), pack(5, 5, 5));
                3: set_triangle(pack(32767, 32767, 32767), pack(-32768, 32767, -32768),
                                pack(32767, -32768, -32768));
                default: set_triangle(small_vertex(), small_vertex(), small_vertex());
            endcase
            calm = (ph == 4);
            for (i = 0; i < 72; i++) send_ray(random_ray());
        end
        calm = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* filelist.f */
hdl/rti_pkg.sv
hdl/rti_mul.sv
hdl/rti_div.sv
hdl/ray_triangle_intersect.sv
dv/tb_ray_triangle_intersect.sv
